FILE: hw/rtl/swg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sine wave gradient plotter: shared definitions
// Widths, register map, queue item and point types, gradient tables and the
// elaboration-time helpers for the quarter-wave sine table.
// ----------------------------------------------------------------------------
package swg_pkg;

  localparam int COLUMN_BITS_DEF     = 12;
  localparam int SINE_TABLE_BITS_DEF = 10;
  localparam int SINE_TABLE_BITS_MAX = 14;
  localparam int ROM_ADDR_MAX_W      = SINE_TABLE_BITS_MAX + 1;

  localparam int PHASE_W      = 32;
  localparam int RATIO_STEP_W = 25;
  localparam int HEIGHT_W     = 12;
  localparam int ORIGIN_W     = 16;
  localparam int PIXEL_W      = 17;
  localparam int CHAN_W       = 8;
  localparam int ENTRY_W      = 15;   // quarter-wave magnitude, Q0.15 without sign
  localparam int SINE_W       = 16;

  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 32;

  // gradient ratio, UQ0.24 with room for exactly one
  localparam int RATIO_FRAC_BITS = 24;
  localparam int RATIO_W         = RATIO_FRAC_BITS + 1;
  localparam int RATIO_ONE       = 1 << RATIO_FRAC_BITS;
  localparam int R6_W            = RATIO_FRAC_BITS + 3;
  localparam int SEG_W           = 3;
  localparam int SEG_LAST        = 5;
  localparam int FRAC_W          = RATIO_FRAC_BITS + 1;
  localparam int BLEND_W         = 36;

  // row arithmetic: scale is 5 * 2^15
  localparam int HS_W          = 30;
  localparam int V_W           = 32;
  localparam int Y_SCALE_SHIFT = 15;
  localparam int Q_W           = 15;
  localparam int RECIP_W       = 16;
  localparam int RECIP_5       = 52429;  // ceil(2^18 / 5), exact for Q_W-bit values
  localparam int RECIP_SHIFT   = 18;
  localparam int MAG_W         = 12;

  localparam int QUEUE_DEPTH = 4;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int OUT_DEPTH   = 8;
  localparam int OCNT_W      = $clog2(OUT_DEPTH + 1);

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PHASE_STEP  = 8'd0,
    REG_RATIO_STEP  = 8'd1,
    REG_PLOT_HEIGHT = 8'd2,
    REG_ORIGIN_X    = 8'd3,
    REG_ORIGIN_Y    = 8'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [PHASE_W-1:0]      phase_step;
    logic [RATIO_STEP_W-1:0] ratio_step;
    logic [HEIGHT_W-1:0]     plot_height;
    logic [ORIGIN_W-1:0]     origin_x;
    logic [ORIGIN_W-1:0]     origin_y;
  } swg_cfg_t;

  // classified item handed from front to back
  typedef struct packed {
    logic [PIXEL_W-1:0]        pixel_x;
    logic [ROM_ADDR_MAX_W-1:0] rom_addr;
    logic                      negate;
    logic [SEG_W-1:0]          seg;
    logic [FRAC_W-1:0]         frac;
  } swg_item_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel_x;
    logic [PIXEL_W-1:0] pixel_y;
    logic [CHAN_W-1:0]  red;
    logic [CHAN_W-1:0]  green;
    logic [CHAN_W-1:0]  blue;
  } swg_point_t;

  // red, orange, yellow, green, blue, indigo, violet
  localparam logic [CHAN_W-1:0] GRAD_RED [7] =
    '{8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd75, 8'd148};
  localparam logic [CHAN_W-1:0] GRAD_GREEN [7] =
    '{8'd0, 8'd165, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0};
  localparam logic [CHAN_W-1:0] GRAD_BLUE [7] =
    '{8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd130, 8'd211};

  // Quarter-wave entry k of 2^table_bits: Taylor series in Q30, rounded to Q15.
  // Only evaluated at elaboration to fill the sine ROM.
  function automatic logic [ENTRY_W-1:0] quarter_entry(input logic [63:0] k,
                                                       input int table_bits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    x  = (k * 64'd1686629713) >> table_bits;
    x2 = (x * x) >> 30;
    t  = 64'd1 << 30;
    t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd156;
    t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd110;
    t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd72;
    t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd42;
    t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd20;
    t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd6;
    s  = (x * t) >> 30;
    s  = (s + (64'd1 << 14)) >> 15;
    if (s > 64'd32767) begin
      s = 64'd32767;
    end
    return s[ENTRY_W-1:0];
  endfunction

  // start + frac * (end - start), UQ0.24 blend, truncated to a byte
  function automatic logic [CHAN_W-1:0] blend(input logic [CHAN_W-1:0] a,
                                              input logic [CHAN_W-1:0] b,
                                              input logic [FRAC_W-1:0] frac);
    logic signed [CHAN_W:0]    diff;
    logic signed [BLEND_W-1:0] prod;
    logic signed [BLEND_W-1:0] num;
    diff = $signed({1'b0, b}) - $signed({1'b0, a});
    prod = $signed({{(BLEND_W-FRAC_W){1'b0}}, frac}) * diff;
    num  = $signed({{(BLEND_W-CHAN_W-RATIO_FRAC_BITS){1'b0}}, a,
                    {RATIO_FRAC_BITS{1'b0}}}) + prod;
    return num[BLEND_W-1] ? '0 : num[RATIO_FRAC_BITS +: CHAN_W];
  endfunction

endpackage

FILE: hw/rtl/swg_intf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sine wave gradient plotter: channel interfaces
// Valid/ready channels for columns in, plotted points out and register writes.
// ----------------------------------------------------------------------------
interface swg_in_if #(
  parameter int COLUMN_BITS = swg_pkg::COLUMN_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [COLUMN_BITS-1:0] column;

  modport source (output valid, output column, input ready);
  modport sink   (input valid, input column, output ready);
endinterface

interface swg_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [swg_pkg::PIXEL_W-1:0]  pixel_x;
  logic signed [swg_pkg::PIXEL_W-1:0]  pixel_y;
  logic        [swg_pkg::CHAN_W-1:0]   red;
  logic        [swg_pkg::CHAN_W-1:0]   green;
  logic        [swg_pkg::CHAN_W-1:0]   blue;

  modport source (output valid, output pixel_x, output pixel_y, output red,
                  output green, output blue, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, input red,
                  input green, input blue, output ready);
endinterface

interface swg_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [swg_pkg::CFG_INDEX_W-1:0]    index;
  logic [swg_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/swg_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sine wave gradient plotter: small register FIFO
// Flop-based queue with occupancy count; head is read combinationally.
// ----------------------------------------------------------------------------
module swg_fifo #(
  parameter int DEPTH = swg_pkg::QUEUE_DEPTH,
  parameter int WIDTH = $bits(swg_pkg::swg_item_t)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         wr_en,
  input  logic [WIDTH-1:0]             wr_data,
  input  logic                         rd_en,
  output logic [WIDTH-1:0]             rd_data,
  output logic                         rd_valid,
  output logic [$clog2(DEPTH+1)-1:0]   count
);
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic [PTR_W-1:0] wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_nxt;
  logic [CNT_W-1:0] count_nxt;

  always_comb begin
    wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    count_nxt  = count_r + CNT_W'(wr_en) - CNT_W'(rd_en);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (rd_en) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  assign rd_data  = mem_r[rd_ptr_r];
  assign rd_valid = (count_r != '0);
  assign count    = count_r;

endmodule

FILE: hw/rtl/swg_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sine wave gradient plotter: front end
// Accepts columns, forms phase and ratio products, and classifies each beat
// into sine table address, sign, gradient segment and fraction.
// ----------------------------------------------------------------------------
module swg_front #(
  parameter int COLUMN_BITS     = swg_pkg::COLUMN_BITS_DEF,
  parameter int SINE_TABLE_BITS = swg_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [COLUMN_BITS-1:0]      in_column,
  input  swg_pkg::swg_cfg_t           cfg,
  input  logic [swg_pkg::QCNT_W-1:0]  q_count,
  output logic                        push_valid,
  output swg_pkg::swg_item_t          push_item
);
  import swg_pkg::*;

  localparam int RPROD_W   = COLUMN_BITS + RATIO_STEP_W;
  localparam int ADDR_W    = SINE_TABLE_BITS + 1;
  localparam int QUARTER_N = 1 << SINE_TABLE_BITS;

  logic                           accept;
  logic [PHASE_W+COLUMN_BITS-1:0] phase_prod;
  logic [RPROD_W-1:0]             ratio_prod;
  logic [PIXEL_W-1:0]             px;

  logic                           f1_valid_r;
  logic [PHASE_W-1:0]             f1_phase_r;
  logic [RPROD_W-1:0]             f1_ratio_r;
  logic [PIXEL_W-1:0]             f1_px_r;

  logic [SINE_TABLE_BITS-1:0]     sine_idx;
  logic [ADDR_W-1:0]              rom_addr;
  logic [RATIO_W-1:0]             ratio_clamped;
  logic [R6_W-1:0]                r6;
  logic [SEG_W-1:0]               seg_raw;
  logic [SEG_W-1:0]               seg;
  logic [FRAC_W-1:0]              frac;

  // room for the beat in the queue, counting the one still in the product stage
  assign in_ready = ((QCNT_W+1)'(q_count) + (QCNT_W+1)'(f1_valid_r))
                    < (QCNT_W+1)'(QUEUE_DEPTH);
  assign accept   = in_valid && in_ready;

  always_comb begin
    phase_prod = {{PHASE_W{1'b0}}, in_column} * {{COLUMN_BITS{1'b0}}, cfg.phase_step};
    ratio_prod = {{RATIO_STEP_W{1'b0}}, in_column} *
                 {{COLUMN_BITS{1'b0}}, cfg.ratio_step};
    px = {cfg.origin_x[ORIGIN_W-1], cfg.origin_x} +
         {{(PIXEL_W-COLUMN_BITS){1'b0}}, in_column};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_valid_r <= 1'b0;
    end else begin
      f1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f1_phase_r <= phase_prod[PHASE_W-1:0];
      f1_ratio_r <= ratio_prod;
      f1_px_r    <= px;
    end
  end

  // classification
  always_comb begin
    // top two phase bits pick the quadrant; odd quadrants run the table backwards
    sine_idx = f1_phase_r[PHASE_W-3 -: SINE_TABLE_BITS];
    if (f1_phase_r[PHASE_W-2]) begin
      rom_addr = ADDR_W'(QUARTER_N) - {1'b0, sine_idx};
    end else begin
      rom_addr = {1'b0, sine_idx};
    end

    if (f1_ratio_r > RPROD_W'(RATIO_ONE)) begin
      ratio_clamped = RATIO_W'(RATIO_ONE);
    end else begin
      ratio_clamped = f1_ratio_r[RATIO_W-1:0];
    end
    r6      = (R6_W'(ratio_clamped) << 2) + (R6_W'(ratio_clamped) << 1);
    seg_raw = r6[R6_W-1 -: SEG_W];
    // ratio of exactly one lands at the end of the last segment
    if (seg_raw > SEG_W'(SEG_LAST)) begin
      seg  = SEG_W'(SEG_LAST);
      frac = FRAC_W'(RATIO_ONE);
    end else begin
      seg  = seg_raw;
      frac = {1'b0, r6[RATIO_FRAC_BITS-1:0]};
    end
  end

  assign push_valid         = f1_valid_r;
  assign push_item.pixel_x  = f1_px_r;
  assign push_item.rom_addr = ROM_ADDR_MAX_W'(rom_addr);
  assign push_item.negate   = f1_phase_r[PHASE_W-1];
  assign push_item.seg      = seg;
  assign push_item.frac     = frac;

endmodule

FILE: hw/rtl/swg_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sine wave gradient plotter: back end
// Sine ROM lookup, row scaling and division by 5*2^15, gradient blend, and
// the output buffer that absorbs receiver stalls.
// ----------------------------------------------------------------------------
module swg_back #(
  parameter int SINE_TABLE_BITS = swg_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  swg_pkg::swg_cfg_t   cfg,
  input  logic                q_valid,
  input  swg_pkg::swg_item_t  q_item,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output swg_pkg::swg_point_t out_point
);
  import swg_pkg::*;

  localparam int ADDR_W    = SINE_TABLE_BITS + 1;
  localparam int ROM_DEPTH = (1 << SINE_TABLE_BITS) + 1;
  localparam int FLIGHT_W  = $clog2(OUT_DEPTH + 1);

  typedef logic [ENTRY_W-1:0] sine_rom_t [ROM_DEPTH];

  function automatic sine_rom_t build_rom();
    sine_rom_t rom;
    for (int k = 0; k < ROM_DEPTH; k++) begin
      rom[k] = quarter_entry(64'(k), SINE_TABLE_BITS);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_rom();

  logic [OCNT_W-1:0]   out_count;
  logic [FLIGHT_W-1:0] flight_r;
  logic                out_pop;
  swg_point_t          wr_point;

  // stage 1: ROM read
  logic                b1_valid_r;
  logic [ENTRY_W-1:0]  b1_rom_r;
  logic [PIXEL_W-1:0]  b1_px_r;
  logic                b1_neg_r;
  logic [SEG_W-1:0]    b1_seg_r;
  logic [FRAC_W-1:0]   b1_frac_r;

  // stage 2: signed sine times height, colour blend
  logic                b2_valid_r;
  logic [PIXEL_W-1:0]  b2_px_r;
  logic signed [HS_W-1:0] b2_hs_r;
  logic [CHAN_W-1:0]   b2_red_r;
  logic [CHAN_W-1:0]   b2_green_r;
  logic [CHAN_W-1:0]   b2_blue_r;

  // stage 3: centre and magnitude
  logic                b3_valid_r;
  logic [PIXEL_W-1:0]  b3_px_r;
  logic [Q_W-1:0]      b3_q_r;
  logic                b3_neg_r;
  logic [CHAN_W-1:0]   b3_red_r;
  logic [CHAN_W-1:0]   b3_green_r;
  logic [CHAN_W-1:0]   b3_blue_r;

  // stage 4: divide by five
  logic                b4_valid_r;
  logic [PIXEL_W-1:0]  b4_px_r;
  logic [MAG_W-1:0]    b4_mag_r;
  logic                b4_neg_r;
  logic [CHAN_W-1:0]   b4_red_r;
  logic [CHAN_W-1:0]   b4_green_r;
  logic [CHAN_W-1:0]   b4_blue_r;

  logic signed [SINE_W-1:0]   sine;
  logic signed [HS_W-2:0]     hs;
  logic [SEG_W-1:0]           seg_end;
  logic [13:0]                base5;
  logic signed [V_W-1:0]      v;
  logic [V_W-1:0]             v_abs;
  logic [Q_W+RECIP_W-1:0]     recip_prod;
  logic [MAG_W:0]             dy;

  // only pop when the output buffer is sure to have room for the beat
  assign q_pop = q_valid &&
                 ((FLIGHT_W+1)'(out_count) + (FLIGHT_W+1)'(flight_r)
                  < (FLIGHT_W+1)'(OUT_DEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_valid_r <= 1'b0;
      b2_valid_r <= 1'b0;
      b3_valid_r <= 1'b0;
      b4_valid_r <= 1'b0;
      flight_r   <= '0;
    end else begin
      b1_valid_r <= q_pop;
      b2_valid_r <= b1_valid_r;
      b3_valid_r <= b2_valid_r;
      b4_valid_r <= b3_valid_r;
      flight_r   <= flight_r + FLIGHT_W'(q_pop) - FLIGHT_W'(b4_valid_r);
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      b1_rom_r  <= SINE_ROM[q_item.rom_addr[ADDR_W-1:0]];
      b1_px_r   <= q_item.pixel_x;
      b1_neg_r  <= q_item.negate;
      b1_seg_r  <= q_item.seg;
      b1_frac_r <= q_item.frac;
    end
  end

  always_comb begin
    if (b1_neg_r) begin
      sine = -$signed({1'b0, b1_rom_r});
    end else begin
      sine = $signed({1'b0, b1_rom_r});
    end
    hs      = $signed({1'b0, cfg.plot_height}) * sine;
    seg_end = b1_seg_r + SEG_W'(1);
  end

  always_ff @(posedge clk) begin
    b2_px_r    <= b1_px_r;
    b2_hs_r    <= {hs, 1'b0};
    b2_red_r   <= blend(GRAD_RED[b1_seg_r], GRAD_RED[seg_end], b1_frac_r);
    b2_green_r <= blend(GRAD_GREEN[b1_seg_r], GRAD_GREEN[seg_end], b1_frac_r);
    b2_blue_r  <= blend(GRAD_BLUE[b1_seg_r], GRAD_BLUE[seg_end], b1_frac_r);
  end

  // v = (height/2) * 5*2^15 + 2*height*sine; row is v / (5*2^15) toward zero
  always_comb begin
    base5 = {1'b0, cfg.plot_height[HEIGHT_W-1:1], 2'b00} +
            14'(cfg.plot_height[HEIGHT_W-1:1]);
    v     = $signed({3'b000, base5, {Y_SCALE_SHIFT{1'b0}}}) +
            $signed({{(V_W-HS_W){b2_hs_r[HS_W-1]}}, b2_hs_r});
    v_abs = v[V_W-1] ? V_W'(-v) : V_W'(v);
  end

  always_ff @(posedge clk) begin
    b3_px_r    <= b2_px_r;
    b3_q_r     <= v_abs[Y_SCALE_SHIFT +: Q_W];
    b3_neg_r   <= v[V_W-1];
    b3_red_r   <= b2_red_r;
    b3_green_r <= b2_green_r;
    b3_blue_r  <= b2_blue_r;
  end

  assign recip_prod = {{RECIP_W{1'b0}}, b3_q_r} * {{Q_W{1'b0}}, RECIP_W'(RECIP_5)};

  always_ff @(posedge clk) begin
    b4_px_r    <= b3_px_r;
    b4_mag_r   <= recip_prod[RECIP_SHIFT +: MAG_W];
    b4_neg_r   <= b3_neg_r;
    b4_red_r   <= b3_red_r;
    b4_green_r <= b3_green_r;
    b4_blue_r  <= b3_blue_r;
  end

  always_comb begin
    dy = b4_neg_r ? -{1'b0, b4_mag_r} : {1'b0, b4_mag_r};
    wr_point.pixel_x = b4_px_r;
    wr_point.pixel_y = {cfg.origin_y[ORIGIN_W-1], cfg.origin_y} +
                       {{(PIXEL_W-MAG_W-1){dy[MAG_W]}}, dy};
    wr_point.red     = b4_red_r;
    wr_point.green   = b4_green_r;
    wr_point.blue    = b4_blue_r;
  end

  assign out_pop = out_valid && out_ready;

  swg_fifo #(
    .DEPTH (OUT_DEPTH),
    .WIDTH ($bits(swg_point_t))
  ) u_out_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (b4_valid_r),
    .wr_data  (wr_point),
    .rd_en    (out_pop),
    .rd_data  (out_point),
    .rd_valid (out_valid),
    .count    (out_count)
  );

endmodule

FILE: hw/rtl/sine_wave_gradient_plotter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sine wave gradient plotter
// Turns a column index into a screen point on a sine wave, coloured by a
// seven-stop rainbow gradient along the wave.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan  : one column per beat (valid/ready).
//   out_chan : one point per column, pixel_x/pixel_y plus red/green/blue,
//              in the order the columns arrived.
//   cfg_chan : register writes by index (phase_step, ratio_step, plot_height,
//              origin_x, origin_y); always ready, write only while idle.
//              Unknown indexes are dropped.
// Throughput is one column per clock while the receiver does not stall.
// Each point passes through the front product register (phase/ratio
// multiply), the classify-and-queue write, the four-stage back (sine ROM
// read, height multiply, centring, reciprocal divide by five) and the
// output buffer.
// The sine ROM is a constant quarter-wave table built at elaboration, so no
// clearing pass is needed after reset.
// Reset clears the config registers and valid flags and empties both queues.
// When the receiver stalls, up to 8 points wait in the output buffer;
// in_chan.ready drops when front/back queue plus product stage hold 4 beats.
// ----------------------------------------------------------------------------
module sine_wave_gradient_plotter_unit #(
  parameter int COLUMN_BITS     = swg_pkg::COLUMN_BITS_DEF,
  parameter int SINE_TABLE_BITS = swg_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  swg_in_if.sink        in_chan,
  swg_out_if.source     out_chan,
  swg_cfg_if.sink       cfg_chan
);
  import swg_pkg::*;

  swg_cfg_t   cfg_r;
  logic       push_valid;
  swg_item_t  push_item;
  swg_item_t  q_item;
  logic       q_valid;
  logic       q_pop;
  logic [QCNT_W-1:0] q_count;
  swg_point_t out_point;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        REG_PHASE_STEP:  cfg_r.phase_step  <= cfg_chan.data[PHASE_W-1:0];
        REG_RATIO_STEP:  cfg_r.ratio_step  <= cfg_chan.data[RATIO_STEP_W-1:0];
        REG_PLOT_HEIGHT: cfg_r.plot_height <= cfg_chan.data[HEIGHT_W-1:0];
        REG_ORIGIN_X:    cfg_r.origin_x    <= cfg_chan.data[ORIGIN_W-1:0];
        REG_ORIGIN_Y:    cfg_r.origin_y    <= cfg_chan.data[ORIGIN_W-1:0];
        default: ;
      endcase
    end
  end

  swg_front #(
    .COLUMN_BITS     (COLUMN_BITS),
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_chan.valid),
    .in_ready   (in_chan.ready),
    .in_column  (in_chan.column),
    .cfg        (cfg_r),
    .q_count    (q_count),
    .push_valid (push_valid),
    .push_item  (push_item)
  );

  swg_fifo #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH ($bits(swg_item_t))
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (push_valid),
    .wr_data  (push_item),
    .rd_en    (q_pop),
    .rd_data  (q_item),
    .rd_valid (q_valid),
    .count    (q_count)
  );

  swg_back #(
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_point (out_point)
  );

  assign out_chan.pixel_x = out_point.pixel_x;
  assign out_chan.pixel_y = out_point.pixel_y;
  assign out_chan.red     = out_point.red;
  assign out_chan.green   = out_point.green;
  assign out_chan.blue    = out_point.blue;

endmodule
